FILE: hdl/rotation_quaternion_between_vectors_macros.svh
// Assertion macros used by the top-level RTL file of the quaternion block.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ROTATION_QUATERNION_BETWEEN_VECTORS_MACROS_SVH
`define ROTATION_QUATERNION_BETWEEN_VECTORS_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every clock edge outside of reset.
`define RQBV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checks a property on every clock edge, reset included.
`define RQBV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RQBV_ASSERT(label, prop, msg)
`define RQBV_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hdl/rqbv_pkg.sv
package rqbv_pkg;

   // Internal fixed point format: signed Q2.30 in 32 bits.
   localparam int unsigned IQ     = 30;
   localparam int unsigned UNIT_W = 32;
   localparam int unsigned MAG_W  = 31;

   // Normalizer arithmetic sizes.
   localparam int unsigned NORM_SQRT_W = 62;
   localparam int unsigned NORM_ROOT_W = NORM_SQRT_W / 2;
   localparam int unsigned NORM_NUM_W  = 61;
   localparam int unsigned NORM_QW     = 32;

   // Half-angle branch sizes.
   localparam int unsigned GEN_SQRT_W = 64;
   localparam int unsigned GEN_ROOT_W = GEN_SQRT_W / 2;
   localparam int unsigned GEN_NUM_W  = 62;
   localparam int unsigned GEN_QW     = 40;

   // Pipeline latencies in cycles.
   localparam int unsigned NORM_LAT   = 4 + NORM_ROOT_W + 1 + (NORM_QW + 1) + 1;
   localparam int unsigned GEN_LAT    = GEN_ROOT_W + 1 + (GEN_QW + 1);
   localparam int unsigned AXIS_ALIGN = GEN_LAT - NORM_LAT;
   localparam int unsigned PIPE_LAT   = NORM_LAT + 4 + GEN_LAT;

   localparam int unsigned FRAC_BITS_DEFAULT = 14;

   typedef logic signed [UNIT_W-1:0] unit_type;

   localparam unit_type ONE_Q        = 32'sh4000_0000;
   localparam unit_type OPP_LIM_GEN  = -32'sh4000_0000 + 32'sd1073742;
   localparam unit_type OPP_LIM_Y    = -32'sh4000_0000 + 32'sd10737;
   localparam logic [MAG_W-1:0] MAG_LIMIT = 31'h2000_0000;
   localparam logic signed [63:0] ONE_WIDE      = 64'sh0000_0000_4000_0000;
   localparam logic signed [63:0] AXIS_MIN_LEN2 = 64'sd115292150460685;

   // Per-item flags that ride alongside the half-angle branch.
   typedef struct packed {
      logic mode_y;
      logic ok;
      logic opp;
   } flags_type;

   // Arithmetic right shift with rounding half away from zero.
   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                    input int unsigned n);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? (~v + 64'd1) : v;
      if (n == 0) begin
         r = m;
      end else begin
         r = (m + (64'd1 << (n - 1))) >> n;
      end
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   // Limits a value to the range of plus or minus one.
   function automatic unit_type clamp_one(input logic signed [63:0] v);
      unit_type r;
      if (v > ONE_WIDE) begin
         r = ONE_Q;
      end else if (v < -ONE_WIDE) begin
         r = -ONE_Q;
      end else begin
         r = v[UNIT_W-1:0];
      end
      return r;
   endfunction

   // Rounds a Q2.30 value to the output format and saturates to 16 bits.
   function automatic logic signed [15:0] to_out(input logic signed [63:0] v,
                                                 input int unsigned n);
      logic signed [63:0] r;
      logic signed [15:0] o;
      r = shr_round(v, n);
      if (r > 64'sd32767) begin
         o = 16'sh7fff;
      end else if (r < -64'sd32768) begin
         o = -16'sh8000;
      end else begin
         o = r[15:0];
      end
      return o;
   endfunction

endpackage

FILE: hdl/rotation_quaternion_between_vectors.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   func, start x/y/z, dest x/y/z
// rsp      out        rsp_valid/rsp_stall   quat w/x/y/z, opposite_case, zero_vector_error
//
// A new transaction is taken every cycle while no stalled result holds the output register.
// The pipe is two parallel normalizers followed by the half-angle branch, each built of a
// bit-per-stage square root followed by bit-per-stage restoring dividers.
// Reset is synchronous and clears only the valid bits, so the pipe comes up empty.
// While the output register holds a transaction that is stalled, the whole pipe holds.
module rotation_quaternion_between_vectors
   import rqbv_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_start_z,
   input  logic signed [15:0] req_dest_x,
   input  logic signed [15:0] req_dest_y,
   input  logic signed [15:0] req_dest_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic               rsp_opposite_case,
   output logic               rsp_zero_vector_error
);

`include "rotation_quaternion_between_vectors_macros.svh"

   localparam int unsigned OUT_SHIFT = IQ - FRAC_BITS;

   logic en;

   unit_type raw_s [3];
   unit_type raw_d [3];
   unit_type s_n   [3];
   unit_type d_n   [3];
   logic     s_nz;
   logic     d_nz;
   logic     func_dl [NORM_LAT];
   logic     vld_pipe_ff [PIPE_LAT];

   // Stage C1 registers.
   logic signed [63:0] p_dot_ff [3];
   logic signed [63:0] p_cr_ff  [6];
   logic signed [63:0] p_ax_ff  [2];
   unit_type           s1_ff    [3];
   unit_type           s_sel    [3];
   logic               mode1_ff;
   logic               ok1_ff;

   // Stage C2 registers.
   logic signed [63:0] dot_ff;
   logic signed [63:0] crd_ff [3];
   logic signed [63:0] axl_ff;
   unit_type           s2_ff  [3];
   logic               mode2_ff;
   logic               ok2_ff;

   // Stage C3 registers.
   unit_type           cos_ff;
   logic signed [32:0] cr_ff  [3];
   unit_type           ax_ff  [3];
   logic               mode3_ff;
   logic               ok3_ff;
   logic signed [63:0] cr_rnd [3];
   logic               ax_small;

   // Stage C4 registers.
   logic signed [32:0] t_sum;
   logic [63:0]        rad_ff;
   logic [31:0]        crm_ff [3];
   logic               crn_ff [3];
   unit_type           ax4_ff [3];
   flags_type          flg_ff;
   logic signed [32:0] cr_neg [3];

   // Half-angle branch.
   logic [GEN_ROOT_W-1:0]  sq;
   logic [31:0]            crm_dl [GEN_ROOT_W][3];
   logic                   crn_dl [GEN_ROOT_W][3];
   logic [GEN_NUM_W-1:0]   gnum_ff [3];
   logic                   gneg_ff [3];
   logic [GEN_ROOT_W-1:0]  gden_ff;
   logic [31:0]            q0_ff;
   logic [32:0]            q0_sum;
   logic [31:0]            q0_dl [GEN_QW+1];
   logic signed [GEN_QW:0] gq [3];
   flags_type              flg_dl [GEN_LAT];

   // Axis branch for the opposite case.
   unit_type an   [3];
   unit_type an_dl [AXIS_ALIGN][3];

   logic signed [63:0] qv [4];
   flags_type          fin;

   logic               rsp_valid_ff;
   logic signed [15:0] quat_ff [4];
   logic               opp_out_ff;
   logic               err_out_ff;

   // The pipe advances unless a finished transaction waits at the output.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Scale the 16-bit inputs into the internal format.
   assign raw_s[0] = {req_start_x[15], req_start_x, 15'b0};
   assign raw_s[1] = {req_start_y[15], req_start_y, 15'b0};
   assign raw_s[2] = {req_start_z[15], req_start_z, 15'b0};
   assign raw_d[0] = {req_dest_x[15], req_dest_x, 15'b0};
   assign raw_d[1] = {req_dest_y[15], req_dest_y, 15'b0};
   assign raw_d[2] = {req_dest_z[15], req_dest_z, 15'b0};

   rqbv_norm3 u_norm_start (
      .clock   (clock),
      .en      (en),
      .vec_in  (raw_s),
      .vec_out (s_n),
      .nonzero (s_nz)
   );

   rqbv_norm3 u_norm_dest (
      .clock   (clock),
      .en      (en),
      .vec_in  (raw_d),
      .vec_out (d_n),
      .nonzero (d_nz)
   );

   // Valid bits and the mode bit travel with the normalizers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PIPE_LAT; j++) begin
            vld_pipe_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_pipe_ff[0] <= req_valid;
         for (int j = 1; j < PIPE_LAT; j++) begin
            vld_pipe_ff[j] <= vld_pipe_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func_dl[0] <= req_func;
         for (int j = 1; j < NORM_LAT; j++) begin
            func_dl[j] <= func_dl[j-1];
         end
      end
   end

   // C1: pick the start vector and form all products.
   always_comb begin
      if (func_dl[NORM_LAT-1]) begin
         s_sel[0] = '0;
         s_sel[1] = ONE_Q;
         s_sel[2] = '0;
      end else begin
         s_sel = s_n;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_dot_ff[i] <= s_sel[i] * d_n[i];
         end
         p_cr_ff[0] <= s_sel[1] * d_n[2];
         p_cr_ff[1] <= s_sel[2] * d_n[1];
         p_cr_ff[2] <= s_sel[2] * d_n[0];
         p_cr_ff[3] <= s_sel[0] * d_n[2];
         p_cr_ff[4] <= s_sel[0] * d_n[1];
         p_cr_ff[5] <= s_sel[1] * d_n[0];
         p_ax_ff[0] <= s_sel[2] * s_sel[2];
         p_ax_ff[1] <= s_sel[0] * s_sel[0];
         s1_ff      <= s_sel;
         mode1_ff   <= func_dl[NORM_LAT-1];
         ok1_ff     <= d_nz && (func_dl[NORM_LAT-1] || s_nz);
      end
   end

   // C2: dot product, cross product and fallback axis length.
   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff    <= p_dot_ff[0] + p_dot_ff[1] + p_dot_ff[2];
         crd_ff[0] <= p_cr_ff[0] - p_cr_ff[1];
         crd_ff[1] <= p_cr_ff[2] - p_cr_ff[3];
         crd_ff[2] <= p_cr_ff[4] - p_cr_ff[5];
         axl_ff    <= p_ax_ff[0] + p_ax_ff[1];
         s2_ff     <= s1_ff;
         mode2_ff  <= mode1_ff;
         ok2_ff    <= ok1_ff;
      end
   end

   // C3: round to the internal format and choose the fallback axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_rnd[i] = shr_round(crd_ff[i], IQ);
      end
      ax_small = (axl_ff < AXIS_MIN_LEN2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= clamp_one(shr_round(dot_ff, IQ));
         for (int i = 0; i < 3; i++) begin
            cr_ff[i] <= cr_rnd[i][32:0];
         end
         if (ax_small) begin
            ax_ff[0] <= '0;
            ax_ff[1] <= -s2_ff[2];
            ax_ff[2] <= s2_ff[1];
         end else begin
            ax_ff[0] <= s2_ff[2];
            ax_ff[1] <= '0;
            ax_ff[2] <= -s2_ff[0];
         end
         mode3_ff <= mode2_ff;
         ok3_ff   <= ok2_ff;
      end
   end

   // C4: opposite test and the radicand 2 * (1 + cos) in Q60.
   always_comb begin
      t_sum = 33'(cos_ff) + 33'(ONE_Q);
      for (int i = 0; i < 3; i++) begin
         cr_neg[i] = -cr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= {1'b0, t_sum[31:0], 31'b0};
         for (int i = 0; i < 3; i++) begin
            crm_ff[i] <= cr_ff[i][32] ? cr_neg[i][31:0] : cr_ff[i][31:0];
            crn_ff[i] <= cr_ff[i][32];
         end
         ax4_ff        <= ax_ff;
         flg_ff.mode_y <= mode3_ff;
         flg_ff.ok     <= ok3_ff;
         flg_ff.opp    <= ok3_ff && (cos_ff < (mode3_ff ? OPP_LIM_Y : OPP_LIM_GEN));
      end
   end

   rqbv_sqrt #(
      .IN_W (GEN_SQRT_W)
   ) u_sqrt_half (
      .clock    (clock),
      .en       (en),
      .radicand (rad_ff),
      .root     (sq)
   );

   // Hold the cross product and the flags while the square root runs.
   always_ff @(posedge clock) begin
      if (en) begin
         crm_dl[0] <= crm_ff;
         crn_dl[0] <= crn_ff;
         for (int j = 1; j < GEN_ROOT_W; j++) begin
            crm_dl[j] <= crm_dl[j-1];
            crn_dl[j] <= crn_dl[j-1];
         end
         flg_dl[0] <= flg_ff;
         for (int j = 1; j < GEN_LAT; j++) begin
            flg_dl[j] <= flg_dl[j-1];
         end
      end
   end

   // Numerators for cross / s and the scalar part s / 2.
   assign q0_sum = 33'(sq) + 33'd1;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            gnum_ff[i] <= {crm_dl[GEN_ROOT_W-1][i], 30'b0} + GEN_NUM_W'(sq >> 1);
            gneg_ff[i] <= crn_dl[GEN_ROOT_W-1][i];
         end
         gden_ff <= sq;
         q0_ff   <= q0_sum[32:1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_gdiv
      rqbv_div #(
         .NUM_W (GEN_NUM_W),
         .DEN_W (GEN_ROOT_W),
         .QW    (GEN_QW)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (gnum_ff[i]),
         .den   (gden_ff),
         .neg   (gneg_ff[i]),
         .quot  (gq[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q0_dl[0] <= q0_ff;
         for (int j = 1; j < GEN_QW + 1; j++) begin
            q0_dl[j] <= q0_dl[j-1];
         end
      end
   end

   // The fallback axis is normalized in parallel and aligned to the other branch.
   rqbv_norm3 u_norm_axis (
      .clock   (clock),
      .en      (en),
      .vec_in  (ax4_ff),
      .vec_out (an),
      .nonzero ()
   );

   always_ff @(posedge clock) begin
      if (en) begin
         an_dl[0] <= an;
         for (int j = 1; j < AXIS_ALIGN; j++) begin
            an_dl[j] <= an_dl[j-1];
         end
      end
   end

   // Select the result for the case at hand.
   always_comb begin
      fin = flg_dl[GEN_LAT-1];
      if (!fin.ok) begin
         for (int i = 0; i < 4; i++) begin
            qv[i] = '0;
         end
      end else if (fin.opp && fin.mode_y) begin
         qv[0] = '0;
         qv[1] = ONE_WIDE;
         qv[2] = '0;
         qv[3] = '0;
      end else if (fin.opp) begin
         qv[0] = '0;
         for (int i = 0; i < 3; i++) begin
            qv[i+1] = 64'(an_dl[AXIS_ALIGN-1][i]);
         end
      end else begin
         qv[0] = $signed({32'b0, q0_dl[GEN_QW]});
         for (int i = 0; i < 3; i++) begin
            qv[i+1] = 64'(gq[i]);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_pipe_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            quat_ff[i] <= to_out(qv[i], OUT_SHIFT);
         end
         opp_out_ff <= fin.ok && fin.opp;
         err_out_ff <= !fin.ok;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_quat_w            = quat_ff[0];
   assign rsp_quat_x            = quat_ff[1];
   assign rsp_quat_y            = quat_ff[2];
   assign rsp_quat_z            = quat_ff[3];
   assign rsp_opposite_case     = opp_out_ff;
   assign rsp_zero_vector_error = err_out_ff;

   // A zero-length input never reports the opposite case and gives a zero quaternion.
   `RQBV_ASSERT(a_err_excl, rsp_valid |-> !(rsp_zero_vector_error && rsp_opposite_case), "error and opposite flags together")
   `RQBV_ASSERT(a_err_zero, (rsp_valid && rsp_zero_vector_error) |-> (rsp_quat_w == 16'sd0 && rsp_quat_x == 16'sd0 && rsp_quat_y == 16'sd0 && rsp_quat_z == 16'sd0), "nonzero quaternion on error")
   // A taken transaction with nothing behind it leaves the output empty.
   `RQBV_ASSERT(a_no_extra, (rsp_valid && !rsp_stall && !vld_pipe_ff[PIPE_LAT-1]) |=> !rsp_valid, "result without a transaction")
   // The pipe comes out of reset empty.
   `RQBV_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !vld_pipe_ff[0]), "valid after reset")

endmodule

FILE: hdl/rqbv_sqrt.sv
module rqbv_sqrt #(
   parameter int unsigned IN_W = 62
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);

   localparam int unsigned RT_W  = IN_W / 2;
   localparam int unsigned REM_W = RT_W + 4;

   logic [REM_W-1:0] rem_ff  [RT_W];
   logic [RT_W-1:0]  root_ff [RT_W];
   logic [IN_W-1:0]  bits_ff [RT_W];

   // One root bit per stage: bring down two radicand bits and try the next digit.
   for (genvar j = 0; j < RT_W; j++) begin : g_step
      logic [REM_W-1:0] rem_p;
      logic [REM_W-1:0] r2;
      logic [REM_W-1:0] trial;
      logic [RT_W-1:0]  root_p;
      logic [IN_W-1:0]  bits_p;
      logic [REM_W-1:0] rem_in;
      logic [RT_W-1:0]  root_in;
      logic [IN_W-1:0]  bits_in;

      if (j == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign bits_p = radicand;
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign root_p = root_ff[j-1];
         assign bits_p = bits_ff[j-1];
      end

      assign r2    = {rem_p[REM_W-3:0], bits_p[IN_W-1:IN_W-2]};
      assign trial = REM_W'({root_p, 2'b01});

      always_comb begin
         bits_in = {bits_p[IN_W-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_in  = r2 - trial;
            root_in = {root_p[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = r2;
            root_in = {root_p[RT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            bits_ff[j] <= bits_in;
         end
      end
   end

   assign root = root_ff[RT_W-1];

endmodule

FILE: hdl/rqbv_div.sv
module rqbv_div #(
   parameter int unsigned NUM_W = 61,
   parameter int unsigned DEN_W = 31,
   parameter int unsigned QW    = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   input  logic                neg,
   output logic signed [QW:0]  quot
);

   // The caller guarantees that the upper numerator bits are below the divisor.
   logic [DEN_W-1:0] rem_ff [QW];
   logic [QW-1:0]    low_ff [QW];
   logic [DEN_W-1:0] den_ff [QW];
   logic             neg_ff [QW];
   logic signed [QW:0] quot_ff;
   logic signed [QW:0] quot_in;

   // One quotient bit per stage; quotient bits fill the word as numerator bits leave.
   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [DEN_W-1:0] rem_p;
      logic [QW-1:0]    low_p;
      logic [DEN_W-1:0] den_p;
      logic             neg_p;
      logic [DEN_W:0]   r2;
      logic [DEN_W-1:0] rem_in;
      logic [QW-1:0]    low_in;

      if (j == 0) begin : g_first
         assign rem_p = DEN_W'(num[NUM_W-1:QW]);
         assign low_p = num[QW-1:0];
         assign den_p = den;
         assign neg_p = neg;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign low_p = low_ff[j-1];
         assign den_p = den_ff[j-1];
         assign neg_p = neg_ff[j-1];
      end

      assign r2 = {rem_p, low_p[QW-1]};

      always_comb begin
         if (r2 >= {1'b0, den_p}) begin
            rem_in = DEN_W'(r2 - {1'b0, den_p});
            low_in = {low_p[QW-2:0], 1'b1};
         end else begin
            rem_in = r2[DEN_W-1:0];
            low_in = {low_p[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= low_in;
            den_ff[j] <= den_p;
            neg_ff[j] <= neg_p;
         end
      end
   end

   // Apply the sign of the numerator to the magnitude quotient.
   assign quot_in = neg_ff[QW-1] ? -$signed({1'b0, low_ff[QW-1]})
                                 : $signed({1'b0, low_ff[QW-1]});

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

FILE: hdl/rqbv_norm3.sv
module rqbv_norm3
   import rqbv_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  unit_type vec_in  [3],
   output unit_type vec_out [3],
   output logic     nonzero
);

   localparam int unsigned SH_DLY = NORM_ROOT_W + 2;
   localparam int unsigned NZ_DLY = NORM_ROOT_W + 2 + 1 + NORM_QW + 1;

   logic [MAG_W-1:0] mag_in [3];
   logic [MAG_W-1:0] mag_ff [3];
   logic             neg_ff [3];
   logic [MAG_W-1:0] mx_in;
   logic [MAG_W-1:0] mx_ff;

   logic [4:0]       msb;
   logic [4:0]       shift;
   logic [MAG_W-1:0] sh_in  [3];
   logic [MAG_W-1:0] sh_ff  [3];
   logic             neg2_ff [3];
   logic             nz_ff;

   logic [2*MAG_W-1:0] sqr_ff [3];
   logic [2*MAG_W-1:0] len2_ff;
   logic [NORM_ROOT_W-1:0] len;

   logic [MAG_W-1:0] sh_dl  [SH_DLY][3];
   logic             neg_dl [SH_DLY][3];
   logic             nz_dl  [NZ_DLY];

   logic [NORM_NUM_W-1:0]  num_ff  [3];
   logic                   negn_ff [3];
   logic [NORM_ROOT_W-1:0] den_ff;
   logic signed [NORM_QW:0] quot [3];
   unit_type vec_ff [3];
   logic     nonzero_ff;

   // Take magnitudes and the largest one.
   always_comb begin
      unit_type t;
      mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         t = vec_in[i][UNIT_W-1] ? -vec_in[i] : vec_in[i];
         mag_in[i] = t[MAG_W-1:0];
         if (mag_in[i] > mx_in) begin
            mx_in = mag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            neg_ff[i] <= vec_in[i][UNIT_W-1];
         end
         mx_ff <= mx_in;
      end
   end

   // Scale the vector up until its largest part reaches one half.
   always_comb begin
      msb = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (mx_ff[b]) begin
            msb = 5'(b);
         end
      end
      shift = (mx_ff >= MAG_LIMIT) ? 5'd0 : 5'(29 - int'(msb));
      for (int i = 0; i < 3; i++) begin
         sh_in[i] = mag_ff[i] << shift;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sh_ff[i]   <= sh_in[i];
            neg2_ff[i] <= neg_ff[i];
         end
         nz_ff <= (mx_ff != '0);
      end
   end

   // Squares, then their sum.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sqr_ff[i] <= (2*MAG_W)'(sh_ff[i]) * (2*MAG_W)'(sh_ff[i]);
         end
         len2_ff <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
      end
   end

   rqbv_sqrt #(
      .IN_W (NORM_SQRT_W)
   ) u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (len2_ff),
      .root     (len)
   );

   // Hold the scaled parts until the length is known.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sh_dl[0][i]  <= sh_ff[i];
            neg_dl[0][i] <= neg2_ff[i];
         end
         for (int j = 1; j < SH_DLY; j++) begin
            sh_dl[j]  <= sh_dl[j-1];
            neg_dl[j] <= neg_dl[j-1];
         end
         nz_dl[0] <= nz_ff;
         for (int j = 1; j < NZ_DLY; j++) begin
            nz_dl[j] <= nz_dl[j-1];
         end
      end
   end

   // Rounded numerators for the three divisions by the length.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i]  <= {sh_dl[SH_DLY-1][i], 30'b0} + NORM_NUM_W'(len >> 1);
            negn_ff[i] <= neg_dl[SH_DLY-1][i];
         end
         den_ff <= len;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      rqbv_div #(
         .NUM_W (NORM_NUM_W),
         .DEN_W (NORM_ROOT_W),
         .QW    (NORM_QW)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[i]),
         .den   (den_ff),
         .neg   (negn_ff[i]),
         .quot  (quot[i])
      );
   end

   // Clamp to plus or minus one; a zero vector yields zero parts.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            vec_ff[i] <= nz_dl[NZ_DLY-1] ? clamp_one(64'(quot[i])) : '0;
         end
         nonzero_ff <= nz_dl[NZ_DLY-1];
      end
   end

   assign vec_out = vec_ff;
   assign nonzero = nonzero_ff;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import rqbv_pkg::*;

   localparam int OUT_SHIFT  = 30 - FRAC_BITS_DEFAULT;
   localparam int N_RANDOM   = 1200;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_WAIT = 400;

   typedef longint vec3_type [3];

   typedef struct {
      logic               func;
      logic signed [15:0] sx, sy, sz, dx, dy, dz;
   } pair_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
      logic               opp, err;
   } quat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = 1'b0;
   logic signed [15:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [15:0] req_dest_x = '0, req_dest_y = '0, req_dest_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic               rsp_opposite_case, rsp_zero_vector_error;
   logic               req_taken = 1'b0;

   pair_type pending_pairs[$];
   quat_type expected_quats[$];
   int    mismatches = 0;
   int    pairs_sent = 0;
   int    quats_seen = 0;
   int    opp_seen = 0;
   int    zero_seen = 0;
   int    idle_cycles = 0;

   rotation_quaternion_between_vectors u_top (.*);

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Rounding helpers, half away from zero.
   function automatic longint shift_round(longint v, int n);
      longint m;
      if (n == 0) return v;
      m = ((v < 0 ? -v : v) + (64'sd1 <<< (n - 1))) >>> n;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint m;
      if (den <= 0) return 0;
      m = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -m : m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   // Scales a vector to unit length in Q2.30; returns 0 for an all-zero vector.
   function automatic bit unit_vector(input vec3_type a, output vec3_type u);
      longint          v[3];
      longint unsigned mx, len2, len;
      mx = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = a[i];
         if ((v[i] < 0 ? -v[i] : v[i]) > mx) mx = v[i] < 0 ? -v[i] : v[i];
      end
      if (mx == 0) begin
         u = '{0, 0, 0};
         return 0;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
         mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) len2 += longint'(v[i] * v[i]);
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++)
         u[i] = clamp_unit(div_round(v[i] * 64'sd1073741824, longint'(len)));
      return 1;
   endfunction

   function automatic logic signed [15:0] out_field(longint q);
      longint v;
      v = shift_round(q, OUT_SHIFT);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Computes the shortest-arc quaternion expected for one vector pair.
   function automatic quat_type shortest_arc(pair_type p);
      vec3_type raw, s, d, ax, an;
      longint   q[4], cr[3], c, t, sq;
      bit       ok;
      bit       opp;
      quat_type r;
      q = '{0, 0, 0, 0};
      opp = 0;
      raw = '{longint'(p.dx) * 32768, longint'(p.dy) * 32768, longint'(p.dz) * 32768};
      ok = unit_vector(raw, d);
      if (p.func) begin
         s = '{0, 64'sd1073741824, 0};
      end else begin
         raw = '{longint'(p.sx) * 32768, longint'(p.sy) * 32768, longint'(p.sz) * 32768};
         if (!unit_vector(raw, s)) ok = 0;
      end
      if (ok) begin
         c = clamp_unit(shift_round(s[0] * d[0] + s[1] * d[1] + s[2] * d[2], 30));
         if (c < -64'sd1073741824 + (p.func ? 64'sd10737 : 64'sd1073742)) begin
            opp = 1;
            if (p.func) begin
               q[1] = 64'sd1073741824;
            end else begin
               // Half-turn axis: cross with Y, or with X when that is too short.
               ax = '{s[2], 0, -s[0]};
               if (s[2] * s[2] + s[0] * s[0] < 64'sd115292150460685) ax = '{0, -s[2], s[1]};
               void'(unit_vector(ax, an));
               q[1] = an[0];
               q[2] = an[1];
               q[3] = an[2];
            end
         end else begin
            cr[0] = shift_round(s[1] * d[2] - s[2] * d[1], 30);
            cr[1] = shift_round(s[2] * d[0] - s[0] * d[2], 30);
            cr[2] = shift_round(s[0] * d[1] - s[1] * d[0], 30);
            t = 2 * (64'sd1073741824 + c);
            sq = longint'(int_sqrt(longint'(t) << 30));
            q[0] = shift_round(sq, 1);
            for (int i = 0; i < 3; i++) q[1 + i] = div_round(cr[i] * 64'sd1073741824, sq);
         end
      end
      r.w = out_field(q[0]);
      r.x = out_field(q[1]);
      r.y = out_field(q[2]);
      r.z = out_field(q[3]);
      r.opp = opp;
      r.err = !ok;
      return r;
   endfunction

   function automatic pair_type make_pair(logic f, int sx, int sy, int sz, int dx, int dy,
                                          int dz);
      pair_type p;
      p.func = f;
      p.sx = sx[15:0];
      p.sy = sy[15:0];
      p.sz = sz[15:0];
      p.dx = dx[15:0];
      p.dy = dy[15:0];
      p.dz = dz[15:0];
      return p;
   endfunction

   function automatic logic signed [15:0] rand16();
      return $urandom;
   endfunction

   // Random pair: mostly general vectors, with near-opposite, tiny and zero vectors mixed in.
   function automatic pair_type random_pair();
      pair_type p;
      int       kind;
      kind = $urandom_range(0, 9);
      p.func = $urandom;
      p.sx = rand16();
      p.sy = rand16();
      p.sz = rand16();
      p.dx = rand16();
      p.dy = rand16();
      p.dz = rand16();
      if (kind < 2) begin
         p.dx = -p.sx + $signed(16'($urandom_range(0, 6))) - 3;
         p.dy = -p.sy + $signed(16'($urandom_range(0, 6))) - 3;
         p.dz = -p.sz + $signed(16'($urandom_range(0, 6))) - 3;
         if (p.func) begin
            p.dx = $signed(16'($urandom_range(0, 4))) - 2;
            p.dy = -16'sd1 - 16'($urandom_range(0, 30000));
            p.dz = $signed(16'($urandom_range(0, 4))) - 2;
         end
      end else if (kind == 2) begin
         p.sx = $signed(16'($urandom_range(0, 6))) - 3;
         p.sz = $signed(16'($urandom_range(0, 6))) - 3;
         p.dx = -p.sx;
         p.dy = -p.sy;
         p.dz = -p.sz;
      end else if (kind == 3) begin
         p.dx = $signed(16'($urandom_range(0, 4))) - 2;
         p.dy = $signed(16'($urandom_range(0, 4))) - 2;
         p.dz = $signed(16'($urandom_range(0, 4))) - 2;
      end else if (kind == 4 && $urandom_range(0, 3) == 0) begin
         if ($urandom & 1) begin
            p.sx = 0;
            p.sy = 0;
            p.sz = 0;
         end else begin
            p.dx = 0;
            p.dy = 0;
            p.dz = 0;
         end
      end
      return p;
   endfunction

   // Directed pairs first, then the random stream.
   initial begin
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 100, 0, 0));
      pending_pairs.push_back(make_pair(0, 100, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(1, 5, 5, 5, 0, 0, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 16384, 0));
      pending_pairs.push_back(make_pair(1, -1, -1, -1, 0, -16384, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, -32768, 0));
      pending_pairs.push_back(make_pair(0, 16384, 0, 0, -16384, 0, 0));
      pending_pairs.push_back(make_pair(0, 0, 16384, 0, 0, -16384, 0));
      pending_pairs.push_back(make_pair(0, 0, -32768, 0, 0, 32767, 0));
      pending_pairs.push_back(make_pair(0, 1, 2, 3, -1, -2, -3));
      pending_pairs.push_back(make_pair(0, 32767, 32767, 32767, -32768, -32768, -32768));
      pending_pairs.push_back(make_pair(0, -32768, -32768, -32768, 32767, 32767, 32767));
      pending_pairs.push_back(make_pair(0, 32767, -32768, 32767, 32767, -32768, 32767));
      pending_pairs.push_back(make_pair(0, 1, 0, 0, 0, 1, 0));
      pending_pairs.push_back(make_pair(0, 1, 1, 1, 1, 1, 1));
      pending_pairs.push_back(make_pair(0, 16384, 0, 0, 0, 0, 16384));
      pending_pairs.push_back(make_pair(0, -1, 0, 0, 1, 0, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 1, -30000));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 32767, 32767, 32767));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, -32768, 0, -32768));
      for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());
   end

   // Reset sequence.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Remember whether the request was taken at the last rising edge.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // Request driver: bursts of transactions separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      pair_type p;
      logic     next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_pairs.size() > 0) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
            end
            p = pending_pairs.pop_front();
            burst_left--;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            next_valid = 1'b1;
            req_func <= p.func;
            req_start_x <= p.sx;
            req_start_y <= p.sy;
            req_start_z <= p.sz;
            req_dest_x <= p.dx;
            req_dest_y <= p.dy;
            req_dest_z <= p.dz;
         end
      end
      req_valid <= next_valid;
   end

   // Response stall pattern: phases of no stall, random stall and periodic stall.
   int stall_phase = 0;
   int stall_count = 0;
   always @(negedge clock) begin
      stall_count++;
      if (stall_count % 97 == 0) stall_phase = $urandom_range(0, 2);
      case (stall_phase)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_stall <= (stall_count % 5) < 2;
         end
      endcase
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      quat_type e;
      pair_type p;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            p.func = req_func;
            p.sx = req_start_x;
            p.sy = req_start_y;
            p.sz = req_start_z;
            p.dx = req_dest_x;
            p.dy = req_dest_y;
            p.dz = req_dest_z;
            expected_quats.push_back(shortest_arc(p));
            pairs_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            quats_seen++;
            if (rsp_opposite_case) opp_seen++;
            if (rsp_zero_vector_error) zero_seen++;
            if (expected_quats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response transaction at %0t", $time);
            end else begin
               e = expected_quats.pop_front();
               if (rsp_quat_w !== e.w || rsp_quat_x !== e.x || rsp_quat_y !== e.y ||
                   rsp_quat_z !== e.z || rsp_opposite_case !== e.opp ||
                   rsp_zero_vector_error !== e.err) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: exp w%0d x%0d y%0d z%0d o%b e%b, got w%0d x%0d y%0d z%0d o%b e%b",
                              $time, e.w, e.x, e.y, e.z, e.opp, e.err, rsp_quat_w, rsp_quat_x,
                              rsp_quat_y, rsp_quat_z, rsp_opposite_case, rsp_zero_vector_error);
               end
            end
         end
         // Watchdog on cycles where no transaction moves on either channel.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("[rotation_quaternion_between_vectors] ERROR");
            $finish;
         end
      end
   end

   // End of run: drain, settle, then report.
   initial begin
      wait (!reset);
      wait (pending_pairs.size() == 0);
      @(posedge clock);
      wait (!req_valid && expected_quats.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatches += expected_quats.size();
      $display("Sent %0d vector pairs, checked %0d quaternions.", pairs_sent, quats_seen);
      $display("Opposite half-turns: %0d, zero-length errors: %0d, mismatches: %0d.",
               opp_seen, zero_seen, mismatches);
      if (mismatches == 0) begin
         $display("[rotation_quaternion_between_vectors] OK");
      end else begin
         $display("[rotation_quaternion_between_vectors] ERROR");
      end
      $finish;
   end

endmodule
